/* hw/rtl/msb_pkg.sv */
// Shared types and constants for the merge sort buffer.
// No dependencies; imported by msb_sort_ctrl and merge_sort_buffer_core.
`timescale 1ns / 1ps

package msb_pkg;

    localparam int CAPACITY = 64;
    localparam int DATA_W   = 32;
    localparam int IDX_W    = $clog2(CAPACITY);
    localparam int CNT_W    = $clog2(CAPACITY + 1);
    localparam int SUM_W    = CNT_W + 2;

    typedef enum logic [2:0] {
        ST_LOAD,
        ST_PASS,
        ST_MRD,
        ST_MWR,
        ST_ERD,
        ST_EWR
    } state_t;

    typedef struct packed {
        logic [1:0]        we;
        logic [IDX_W-1:0]  waddr;
        logic [DATA_W-1:0] wdata;
        logic              re;
        logic [IDX_W-1:0]  raddr_a;
        logic [IDX_W-1:0]  raddr_b;
    } ram_ctrl_t;

    typedef struct packed {
        logic              load;
        logic [DATA_W-1:0] value;
        logic              final_res;
        logic              overflow;
    } out_beat_t;

endpackage

/* hw/rtl/msb_ram.sv */
// Generic synchronous RAM: one write port, two read ports, registered reads.
// No dependencies.
`timescale 1ns / 1ps

module msb_ram #(
    parameter int DEPTH = 64,
    parameter int WIDTH = 32
) (
    input  logic                     aclk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic                     re,
    input  logic [$clog2(DEPTH)-1:0] raddr_a,
    input  logic [$clog2(DEPTH)-1:0] raddr_b,
    output logic [WIDTH-1:0]         rdata_a,
    output logic [WIDTH-1:0]         rdata_b
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge aclk) begin
        if (we) begin
            mem[waddr] <= wdata;
        end
    end

    always_ff @(posedge aclk) begin
        if (re) begin
            rdata_a <= mem[raddr_a];
            rdata_b <= mem[raddr_b];
        end
    end

endmodule

/* hw/rtl/msb_sort_ctrl.sv */
// Sequencer for load, ping-pong merge passes and emission of the sorted run.
// Depends on msb_pkg; drives both RAM banks and the output register.
`timescale 1ns / 1ps

module msb_sort_ctrl (
    input  logic                       aclk,
    input  logic                       aresetn,
    input  logic                       s_valid,
    output logic                       s_ready,
    input  logic [msb_pkg::DATA_W-1:0] s_value,
    input  logic                       s_last,
    input  logic [msb_pkg::DATA_W-1:0] rd0_a,
    input  logic [msb_pkg::DATA_W-1:0] rd0_b,
    input  logic [msb_pkg::DATA_W-1:0] rd1_a,
    input  logic [msb_pkg::DATA_W-1:0] rd1_b,
    output msb_pkg::ram_ctrl_t         ram,
    input  logic                       out_free,
    output msb_pkg::out_beat_t         beat
);

    import msb_pkg::*;

    state_t           state_reg, state_next;
    logic [CNT_W-1:0] count_reg, count_next;
    logic             drop_reg, drop_next;
    logic [CNT_W-1:0] width_reg, width_next;
    logic [CNT_W-1:0] lo_reg, lo_next;
    logic [CNT_W-1:0] mid_reg, mid_next;
    logic [CNT_W-1:0] hi_reg, hi_next;
    logic [CNT_W-1:0] a_reg, a_next;
    logic [CNT_W-1:0] b_reg, b_next;
    logic [CNT_W-1:0] wp_reg, wp_next;
    logic [CNT_W-1:0] k_reg, k_next;
    logic             src_reg, src_next;

    logic [DATA_W-1:0] da, db;
    logic              take_a;
    logic [SUM_W-1:0]  lo_w, width_w, count_w, mid_w, hi_w, width2_w;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= ST_LOAD;
            count_reg <= '0;
            drop_reg  <= 1'b0;
        end else begin
            state_reg <= state_next;
            count_reg <= count_next;
            drop_reg  <= drop_next;
        end
    end

    always_ff @(posedge aclk) begin
        width_reg <= width_next;
        lo_reg    <= lo_next;
        mid_reg   <= mid_next;
        hi_reg    <= hi_next;
        a_reg     <= a_next;
        b_reg     <= b_next;
        wp_reg    <= wp_next;
        k_reg     <= k_next;
        src_reg   <= src_next;
    end

    assign da       = src_reg ? rd1_a : rd0_a;
    assign db       = src_reg ? rd1_b : rd0_b;
    assign take_a   = (a_reg < mid_reg) &&
                      ((b_reg >= hi_reg) || ($signed(da) <= $signed(db)));
    assign lo_w     = SUM_W'(lo_reg);
    assign width_w  = SUM_W'(width_reg);
    assign count_w  = SUM_W'(count_reg);
    assign mid_w    = (lo_w + width_w < count_w) ? lo_w + width_w : count_w;
    assign hi_w     = (lo_w + (width_w << 1) < count_w) ? lo_w + (width_w << 1) : count_w;
    assign width2_w = width_w << 1;

    always_comb begin
        state_next  = state_reg;
        count_next  = count_reg;
        drop_next   = drop_reg;
        width_next  = width_reg;
        lo_next     = lo_reg;
        mid_next    = mid_reg;
        hi_next     = hi_reg;
        a_next      = a_reg;
        b_next      = b_reg;
        wp_next     = wp_reg;
        k_next      = k_reg;
        src_next    = src_reg;
        s_ready     = 1'b0;
        ram.we      = 2'b00;
        ram.waddr   = wp_reg[IDX_W-1:0];
        ram.wdata   = take_a ? da : db;
        ram.re      = 1'b0;
        ram.raddr_a = a_reg[IDX_W-1:0];
        ram.raddr_b = b_reg[IDX_W-1:0];
        beat.load      = 1'b0;
        beat.value     = src_reg ? rd1_a : rd0_a;
        beat.final_res = (CNT_W'(k_reg + 1'b1) == count_reg);
        beat.overflow  = drop_reg;

        unique case (state_reg)
            ST_LOAD: begin
                s_ready = 1'b1;
                if (s_valid) begin
                    if (count_reg < CNT_W'(CAPACITY)) begin
                        ram.we[0]  = 1'b1;
                        ram.waddr  = count_reg[IDX_W-1:0];
                        ram.wdata  = s_value;
                        count_next = count_reg + 1'b1;
                    end else begin
                        drop_next = 1'b1;
                    end
                    if (s_last) begin
                        src_next   = 1'b0;
                        width_next = CNT_W'(1);
                        lo_next    = '0;
                        k_next     = '0;
                        state_next = (count_next > CNT_W'(1)) ? ST_PASS : ST_ERD;
                    end
                end
            end
            ST_PASS: begin
                mid_next   = mid_w[CNT_W-1:0];
                hi_next    = hi_w[CNT_W-1:0];
                a_next     = lo_reg;
                b_next     = mid_w[CNT_W-1:0];
                wp_next    = lo_reg;
                state_next = ST_MRD;
            end
            ST_MRD: begin
                ram.re     = 1'b1;
                state_next = ST_MWR;
            end
            ST_MWR: begin
                ram.we[~src_reg] = 1'b1;
                wp_next = wp_reg + 1'b1;
                if (take_a) begin
                    a_next = a_reg + 1'b1;
                end else begin
                    b_next = b_reg + 1'b1;
                end
                if (CNT_W'(wp_reg + 1'b1) == hi_reg) begin
                    if (hi_reg == count_reg) begin
                        src_next   = ~src_reg;
                        width_next = width2_w[CNT_W-1:0];
                        lo_next    = '0;
                        k_next     = '0;
                        state_next = (width2_w >= count_w) ? ST_ERD : ST_PASS;
                    end else begin
                        lo_next    = hi_reg;
                        state_next = ST_PASS;
                    end
                end else begin
                    state_next = ST_MRD;
                end
            end
            ST_ERD: begin
                ram.re      = 1'b1;
                ram.raddr_a = k_reg[IDX_W-1:0];
                state_next  = ST_EWR;
            end
            ST_EWR: begin
                if (out_free) begin
                    beat.load = 1'b1;
                    if (beat.final_res) begin
                        count_next = '0;
                        drop_next  = 1'b0;
                        state_next = ST_LOAD;
                    end else begin
                        k_next     = k_reg + 1'b1;
                        state_next = ST_ERD;
                    end
                end
            end
            default: begin
                state_next = ST_LOAD;
            end
        endcase
    end

endmodule

/* hw/rtl/merge_sort_buffer_core.sv */
// Top level of the merge sort buffer: two RAM banks, sequencer, output register.
// Depends on msb_pkg, msb_ram and msb_sort_ctrl.
// Loading: one input beat per cycle. Sorting n: ceil(log2 n) passes, each merging
// every element, with a setup state per run pair or lone tail run. Emission reads
// an element, then registers it; sort and emission are paced by one read per element.
// Synchronous active-low reset empties the buffer; the RAM contents are not cleared.
`timescale 1ns / 1ps

module merge_sort_buffer_core (
    input  logic                       aclk,
    input  logic                       aresetn,
    input  logic                       s_valid,
    output logic                       s_ready,
    input  logic signed [msb_pkg::DATA_W-1:0] s_value,
    input  logic                       s_last,
    output logic                       m_valid,
    input  logic                       m_ready,
    output logic signed [msb_pkg::DATA_W-1:0] m_sorted_value,
    output logic                       m_final_res,
    output logic                       m_overflow
);

    import msb_pkg::*;

    ram_ctrl_t         ram;
    out_beat_t         beat;
    logic [DATA_W-1:0] rd0_a, rd0_b, rd1_a, rd1_b;
    logic              out_free;

    logic              m_valid_reg, m_valid_next;
    logic [DATA_W-1:0] m_value_reg;
    logic              m_final_reg;
    logic              m_ovf_reg;

    msb_ram #(.DEPTH(CAPACITY), .WIDTH(DATA_W)) u_bank0 (
        .aclk    (aclk),
        .we      (ram.we[0]),
        .waddr   (ram.waddr),
        .wdata   (ram.wdata),
        .re      (ram.re),
        .raddr_a (ram.raddr_a),
        .raddr_b (ram.raddr_b),
        .rdata_a (rd0_a),
        .rdata_b (rd0_b)
    );

    msb_ram #(.DEPTH(CAPACITY), .WIDTH(DATA_W)) u_bank1 (
        .aclk    (aclk),
        .we      (ram.we[1]),
        .waddr   (ram.waddr),
        .wdata   (ram.wdata),
        .re      (ram.re),
        .raddr_a (ram.raddr_a),
        .raddr_b (ram.raddr_b),
        .rdata_a (rd1_a),
        .rdata_b (rd1_b)
    );

    msb_sort_ctrl u_ctrl (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_valid  (s_valid),
        .s_ready  (s_ready),
        .s_value  (s_value),
        .s_last   (s_last),
        .rd0_a    (rd0_a),
        .rd0_b    (rd0_b),
        .rd1_a    (rd1_a),
        .rd1_b    (rd1_b),
        .ram      (ram),
        .out_free (out_free),
        .beat     (beat)
    );

    assign out_free = !m_valid_reg || m_ready;

    always_comb begin
        m_valid_next = m_valid_reg;
        if (beat.load) begin
            m_valid_next = 1'b1;
        end else if (m_ready) begin
            m_valid_next = 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg <= 1'b0;
        end else begin
            m_valid_reg <= m_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (beat.load) begin
            m_value_reg <= beat.value;
            m_final_reg <= beat.final_res;
            m_ovf_reg   <= beat.overflow;
        end
    end

    assign m_valid        = m_valid_reg;
    assign m_sorted_value = $signed(m_value_reg);
    assign m_final_res    = m_final_reg;
    assign m_overflow     = m_ovf_reg;

endmodule
